@@ rtl/core/iqs_pkg.sv @@
`timescale 1ns / 1ps
// shared types and codes for the ordered id queue
package iqs_pkg;

  localparam int OPCODE_W  = 3;
  localparam int ITEM_ID_W = 8;
  localparam int STAMP_W   = 31;
  localparam int STATUS_W  = 2;
  localparam int COUNT_W   = 5;

  localparam logic [OPCODE_W-1:0] OP_APPEND  = 3'd0;
  localparam logic [OPCODE_W-1:0] OP_INSERT  = 3'd1;
  localparam logic [OPCODE_W-1:0] OP_TAKE    = 3'd2;
  localparam logic [OPCODE_W-1:0] OP_REMOVE  = 3'd3;
  localparam logic [OPCODE_W-1:0] OP_REPLACE = 3'd4;
  localparam logic [OPCODE_W-1:0] OP_LOOKUP  = 3'd5;

  localparam logic [STATUS_W-1:0] STATUS_DONE = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_MISS = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_PUT, S_SCAN_RD, S_SCAN_CHK, S_SHUP_RD, S_SHUP_WR,
    S_TAKE_RD, S_TAKE_CAP, S_SHDN_RD, S_SHDN_WR, S_SRCH_RD, S_SRCH_CHK, S_DONE
  } state_t;

  typedef enum logic [2:0] {PTR_HOLD, PTR_ZERO, PTR_COUNT, PTR_INC, PTR_DEC} ptr_op_t;
  typedef enum logic [1:0] {RD_PTR, RD_PTR_M1, RD_PTR_P1} rd_sel_t;
  typedef enum logic [1:0] {WR_NEW, WR_REPL, WR_MOVE} wr_sel_t;

  typedef struct packed {
    logic                load_in;
    ptr_op_t             ptr_op;
    logic                pos_load;
    logic                rd_en;
    rd_sel_t             rd_sel;
    logic                wr_en;
    wr_sel_t             wr_sel;
    logic                cnt_inc;
    logic                cnt_dec;
    logic                status_wr;
    logic [STATUS_W-1:0] status_val;
    logic                cap_rd;
    logic                publish;
  } cmd_t;

  typedef struct packed {
    logic [OPCODE_W-1:0] op;
    logic                full;
    logic                empty;
    logic                ptr_eq_count;
    logic                ptr_eq_pos;
    logic                ptr_zero;
    logic                ptr_p1_eq_count;
    logic                stamp_gt;
    logic                id_match;
    logic                out_free;
  } sts_t;

endpackage

@@ rtl/core/iqs_ctrl.sv @@
`timescale 1ns / 1ps
// sequencer for the ordered id queue operations
module iqs_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  iqs_pkg::sts_t sts,
  output iqs_pkg::cmd_t cmd
);
  import iqs_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (sts.op)
          OP_APPEND: begin
            if (sts.full) begin
              cmd.status_wr  = 1'b1;
              cmd.status_val = STATUS_FULL;
              state_nxt      = S_DONE;
            end else begin
              cmd.ptr_op = PTR_COUNT;
              state_nxt  = S_PUT;
            end
          end
          OP_INSERT: begin
            if (sts.full) begin
              cmd.status_wr  = 1'b1;
              cmd.status_val = STATUS_FULL;
              state_nxt      = S_DONE;
            end else begin
              cmd.ptr_op = PTR_ZERO;
              state_nxt  = S_SCAN_RD;
            end
          end
          OP_TAKE: begin
            if (sts.empty) begin
              cmd.status_wr  = 1'b1;
              cmd.status_val = STATUS_MISS;
              state_nxt      = S_DONE;
            end else begin
              cmd.ptr_op = PTR_ZERO;
              state_nxt  = S_TAKE_RD;
            end
          end
          OP_REMOVE, OP_REPLACE, OP_LOOKUP: begin
            cmd.ptr_op = PTR_COUNT;
            state_nxt  = S_SRCH_RD;
          end
          default: state_nxt = S_DONE;
        endcase
      end
      S_PUT: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_sel  = WR_NEW;
        cmd.cnt_inc = 1'b1;
        state_nxt   = S_DONE;
      end
      S_SCAN_RD: begin
        if (sts.ptr_eq_count) begin
          cmd.pos_load = 1'b1;
          cmd.ptr_op   = PTR_COUNT;
          state_nxt    = S_SHUP_RD;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_PTR;
          state_nxt  = S_SCAN_CHK;
        end
      end
      S_SCAN_CHK: begin
        if (sts.stamp_gt) begin
          cmd.pos_load = 1'b1;
          cmd.ptr_op   = PTR_COUNT;
          state_nxt    = S_SHUP_RD;
        end else begin
          cmd.ptr_op = PTR_INC;
          state_nxt  = S_SCAN_RD;
        end
      end
      S_SHUP_RD: begin
        if (sts.ptr_eq_pos) begin
          state_nxt = S_PUT;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_PTR_M1;
          state_nxt  = S_SHUP_WR;
        end
      end
      S_SHUP_WR: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = WR_MOVE;
        cmd.ptr_op = PTR_DEC;
        state_nxt  = S_SHUP_RD;
      end
      S_TAKE_RD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_PTR;
        state_nxt  = S_TAKE_CAP;
      end
      S_TAKE_CAP: begin
        cmd.cap_rd = 1'b1;
        state_nxt  = S_SHDN_RD;
      end
      S_SHDN_RD: begin
        if (sts.ptr_p1_eq_count) begin
          cmd.cnt_dec = 1'b1;
          state_nxt   = S_DONE;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_PTR_P1;
          state_nxt  = S_SHDN_WR;
        end
      end
      S_SHDN_WR: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = WR_MOVE;
        cmd.ptr_op = PTR_INC;
        state_nxt  = S_SHDN_RD;
      end
      S_SRCH_RD: begin
        if (sts.ptr_zero) begin
          cmd.status_wr  = 1'b1;
          cmd.status_val = STATUS_MISS;
          state_nxt      = S_DONE;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_PTR_M1;
          cmd.ptr_op = PTR_DEC;
          state_nxt  = S_SRCH_CHK;
        end
      end
      S_SRCH_CHK: begin
        if (sts.id_match) begin
          cmd.cap_rd = 1'b1;
          if (sts.op == OP_REMOVE) begin
            state_nxt = S_SHDN_RD;
          end else if (sts.op == OP_REPLACE) begin
            cmd.wr_en  = 1'b1;
            cmd.wr_sel = WR_REPL;
            state_nxt  = S_DONE;
          end else begin
            state_nxt = S_DONE;
          end
        end else begin
          state_nxt = S_SRCH_RD;
        end
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.publish = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

@@ rtl/core/iqs_dpath.sv @@
`timescale 1ns / 1ps
// entry memory, pointers, count and result registers of the ordered id queue
module iqs_dpath #(
  parameter int DEPTH   = 16,
  parameter int ID_BITS = 8
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  iqs_pkg::cmd_t                    cmd,
  output iqs_pkg::sts_t                    sts,
  input  logic [iqs_pkg::OPCODE_W-1:0]     in_opcode,
  input  logic [iqs_pkg::ITEM_ID_W-1:0]    in_item_id,
  input  logic [iqs_pkg::ITEM_ID_W-1:0]    in_new_id,
  input  logic [iqs_pkg::STAMP_W-1:0]      in_time_stamp,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [iqs_pkg::STATUS_W-1:0]     out_status,
  output logic [iqs_pkg::ITEM_ID_W-1:0]    out_id,
  output logic [iqs_pkg::STAMP_W-1:0]      out_stamp,
  output logic [iqs_pkg::COUNT_W-1:0]      out_entry_count
);
  import iqs_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  // entry storage, no reset
  logic [ID_BITS-1:0] mem_id    [DEPTH];
  logic [STAMP_W-1:0] mem_stamp [DEPTH];

  logic [OPCODE_W-1:0] op_r;
  logic [ID_BITS-1:0]  id_r, nid_r;
  logic [STAMP_W-1:0]  stamp_r;
  logic [ID_BITS-1:0]  rd_id_r;
  logic [STAMP_W-1:0]  rd_stamp_r;
  logic [CW-1:0]       count_r, count_nxt;
  logic [CW-1:0]       ptr_r, ptr_nxt;
  logic [CW-1:0]       pos_r;
  logic [STATUS_W-1:0] res_status_r;
  logic [ID_BITS-1:0]  res_id_r;
  logic [STAMP_W-1:0]  res_stamp_r;
  logic                out_valid_r;

  logic [CW-1:0]       ptr_m1, ptr_p1, rd_addr_full;
  logic [ID_BITS-1:0]  wr_id;
  logic [STAMP_W-1:0]  wr_stamp;
  logic                out_free;

  assign ptr_m1 = ptr_r - CW'(1);
  assign ptr_p1 = ptr_r + CW'(1);

  always_comb begin
    unique case (cmd.rd_sel)
      RD_PTR_M1: rd_addr_full = ptr_m1;
      RD_PTR_P1: rd_addr_full = ptr_p1;
      default:   rd_addr_full = ptr_r;
    endcase
  end

  always_comb begin
    unique case (cmd.wr_sel)
      WR_REPL: begin
        wr_id    = nid_r;
        wr_stamp = stamp_r;
      end
      WR_MOVE: begin
        wr_id    = rd_id_r;
        wr_stamp = rd_stamp_r;
      end
      default: begin
        wr_id    = id_r;
        wr_stamp = stamp_r;
      end
    endcase
  end

  // one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem_id[ptr_r[AW-1:0]]    <= wr_id;
      mem_stamp[ptr_r[AW-1:0]] <= wr_stamp;
    end
    if (cmd.rd_en) begin
      rd_id_r    <= mem_id[rd_addr_full[AW-1:0]];
      rd_stamp_r <= mem_stamp[rd_addr_full[AW-1:0]];
    end
  end

  always_comb begin
    unique case (cmd.ptr_op)
      PTR_ZERO:  ptr_nxt = '0;
      PTR_COUNT: ptr_nxt = count_r;
      PTR_INC:   ptr_nxt = ptr_p1;
      PTR_DEC:   ptr_nxt = ptr_m1;
      default:   ptr_nxt = ptr_r;
    endcase
  end

  always_comb begin
    count_nxt = count_r;
    if (cmd.cnt_inc) begin
      count_nxt = count_r + CW'(1);
    end else if (cmd.cnt_dec) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ptr_r <= ptr_nxt;
    if (cmd.pos_load) begin
      pos_r <= ptr_r;
    end
    if (cmd.load_in) begin
      op_r    <= in_opcode;
      id_r    <= ID_BITS'(in_item_id);
      nid_r   <= ID_BITS'(in_new_id);
      stamp_r <= in_time_stamp;
    end
  end

  // result of the running operation
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      res_status_r <= STATUS_DONE;
      res_id_r     <= '0;
      res_stamp_r  <= '0;
    end else begin
      if (cmd.status_wr) begin
        res_status_r <= cmd.status_val;
      end
      if (cmd.cap_rd) begin
        res_id_r    <= rd_id_r;
        res_stamp_r <= rd_stamp_r;
      end
    end
  end

  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.publish) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      out_status      <= res_status_r;
      out_id          <= ITEM_ID_W'(res_id_r);
      out_stamp       <= res_stamp_r;
      out_entry_count <= COUNT_W'(count_r);
    end
  end

  assign out_valid = out_valid_r;

  assign sts.op              = op_r;
  assign sts.full            = (count_r == CW'(DEPTH));
  assign sts.empty           = (count_r == '0);
  assign sts.ptr_eq_count    = (ptr_r == count_r);
  assign sts.ptr_eq_pos      = (ptr_r == pos_r);
  assign sts.ptr_zero        = (ptr_r == '0);
  assign sts.ptr_p1_eq_count = (ptr_p1 == count_r);
  assign sts.stamp_gt        = (rd_stamp_r > stamp_r);
  assign sts.id_match        = (rd_id_r == id_r);
  assign sts.out_free        = out_free;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("entry count beyond depth");

  a_no_grow_full: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.cnt_inc |-> (count_r < CW'(DEPTH)))
    else $error("insert into full queue");

  a_no_shrink_empty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.cnt_dec |-> (count_r != '0))
    else $error("removal from empty queue");

  a_read_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd_en |-> (rd_addr_full < count_r))
    else $error("read of an unused entry");

  a_publish_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.publish |-> out_free)
    else $error("result overwrites an untaken result");

endmodule

@@ rtl/core/id_queue_sorted_insert_remove_top.sv @@
`timescale 1ns / 1ps
// top level of the ordered id queue with time stamp sorted insert
//
//   channel | direction | ports                                          | transfer when
//   --------+-----------+------------------------------------------------+--------------------
//   in      | input     | in_opcode in_item_id in_new_id in_time_stamp   | in_valid & !in_stall
//   out     | output    | out_status out_id out_stamp out_entry_count    | out_valid & !out_stall
//
// operation: one op at a time through the entry memory; full or empty refusals and
//   unused codes go straight to the result, append writes at the tail, sorted insert
//   scans from the head for the first later stamp and moves that entry and those behind it up,
//   take head reads entry 0 and moves the rest down, search walks from the tail toward
//   the head, remove then moves the entries after the match down; a stalled result waits
// reset: rst_n is synchronous, clears the entry count, sequencer and output valid;
//   the entry memory itself is not cleared since unused entries are never read
// stalls: in_stall is high from the transfer of an item until its result is
//   registered; a new item may be taken while that result waits on out_stall
module id_queue_sorted_insert_remove_top #(
  parameter int DEPTH   = 16,
  parameter int ID_BITS = 8
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // operation request
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [iqs_pkg::OPCODE_W-1:0]     in_opcode,
  input  logic [iqs_pkg::ITEM_ID_W-1:0]    in_item_id,
  input  logic [iqs_pkg::ITEM_ID_W-1:0]    in_new_id,
  input  logic [iqs_pkg::STAMP_W-1:0]      in_time_stamp,
  // operation result
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [iqs_pkg::STATUS_W-1:0]     out_status,
  output logic [iqs_pkg::ITEM_ID_W-1:0]    out_id,
  output logic [iqs_pkg::STAMP_W-1:0]      out_stamp,
  output logic [iqs_pkg::COUNT_W-1:0]      out_entry_count
);
  import iqs_pkg::*;

  // command and status between sequencer and datapath
  cmd_t cmd;
  sts_t sts;

  iqs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // entry memory, pointer, count and output register
  iqs_dpath #(
    .DEPTH   (DEPTH),
    .ID_BITS (ID_BITS)
  ) u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_opcode       (in_opcode),
    .in_item_id      (in_item_id),
    .in_new_id       (in_new_id),
    .in_time_stamp   (in_time_stamp),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_id          (out_id),
    .out_stamp       (out_stamp),
    .out_entry_count (out_entry_count)
  );

endmodule
